// ===== hdl/place_notation_to_permutation_defines.svh =====
// Assertion macros for the place notation decoder checker.
// Used by pnp_checker.sv only; needs no other file.
`ifndef PLACE_NOTATION_TO_PERMUTATION_DEFINES_SVH
`define PLACE_NOTATION_TO_PERMUTATION_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define PNP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define PNP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pnp_pkg.sv =====
// Shared constants, types and decode functions for the place notation decoder.
// Has no dependencies; every other file but the defines header imports it.
package pnp_pkg;

   localparam int MAX_BELLS = 16;
   localparam int NUM_PAIRS = MAX_BELLS - 1;
   localparam int POS_W     = $clog2(MAX_BELLS);
   localparam int CNT_W     = $clog2(MAX_BELLS + 1);
   localparam int CHAR_W    = 8;
   localparam int PERM_W    = MAX_BELLS * POS_W;

   localparam logic [CNT_W-1:0] BELL_COUNT_RESET = CNT_W'(8);
   localparam logic [CNT_W-1:0] BELL_COUNT_MAX   = CNT_W'(MAX_BELLS);

   // Cross characters, and the lower-case range and offset used for case folding.
   localparam logic [CHAR_W-1:0] CHAR_CROSS_UC = 8'h58;  // 'X'
   localparam logic [CHAR_W-1:0] CHAR_CROSS_LC = 8'h78;  // 'x'
   localparam logic [CHAR_W-1:0] CHAR_DASH     = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CHAR_LC_A     = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CHAR_LC_Z     = 8'h7A;  // 'z'
   localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

   // Bell names 1234567890ETABCD, indexed by place number.
   localparam logic [CHAR_W-1:0] PLACE_NAME_CODES [MAX_BELLS] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h45, 8'h54, 8'h41, 8'h42, 8'h43, 8'h44
   };

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  place;
   } place_type;

   // One character held in the input register.
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } item_type;

   // Case-insensitive lookup of a bell name; hit is low for any other character.
   function automatic place_type decode_place(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] up;
      place_type         r;
      up = ch;
      if (ch inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
         up = ch - CASE_OFFSET;
      end
      r = '0;
      // Names are distinct, so at most one entry matches.
      for (int i = 0; i < MAX_BELLS; i++) begin
         if (PLACE_NAME_CODES[i] == up) begin
            r.hit   = 1'b1;
            r.place = POS_W'(i);
         end
      end
      return r;
   endfunction

   // Pairs from position lo upwards in steps of two, whose upper position is below hi.
   function automatic logic [NUM_PAIRS-1:0] pair_range(input logic [CNT_W-1:0] lo,
                                                      input logic [CNT_W-1:0] hi);
      logic [NUM_PAIRS-1:0] m;
      logic [CNT_W-1:0]     dv;
      m = '0;
      for (int d = 0; d < NUM_PAIRS; d++) begin
         dv   = CNT_W'(d);
         m[d] = (dv >= lo) && ((dv + 1'b1) < hi) && (dv[0] == lo[0]);
      end
      return m;
   endfunction

   // Pairs whose upper position is below the bell count.
   function automatic logic [NUM_PAIRS-1:0] pairs_below(input logic [CNT_W-1:0] n);
      logic [NUM_PAIRS-1:0] m;
      for (int d = 0; d < NUM_PAIRS; d++) begin
         m[d] = (CNT_W'(d) + 1'b1) < n;
      end
      return m;
   endfunction

endpackage

// ===== hdl/pnp_if.sv =====
// Valid/ready channel interfaces for characters in and changes out.
// Depends on pnp_pkg for the payload widths.
interface pnp_req_if;
   import pnp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface pnp_rsp_if;
   import pnp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [NUM_PAIRS-1:0] swap_mask;
   logic [PERM_W-1:0]    permutation;

   modport source (output valid, output swap_mask, output permutation, input ready);
   modport sink   (input valid, input swap_mask, input permutation, output ready);
endinterface

// ===== hdl/pnp_in_stage.sv =====
// Input register for the character channel.
// Depends on pnp_pkg and the pnp_req_if interface.
module pnp_in_stage (
   input  logic              clock,
   input  logic              reset,
   pnp_req_if.sink           req,
   input  logic              advance,
   output pnp_pkg::item_type item
);
   import pnp_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic              accept;

   // A new transaction is taken when the register is empty or is moving on.
   assign req.ready = !valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req.char_code;
         last_ff <= req.last;
      end
   end

   assign item = '{valid: valid_ff, char_code: char_ff, last: last_ff};

endmodule

// ===== hdl/pnp_token.sv =====
// Token state, swap mask and permutation logic with the result register.
// Depends on pnp_pkg and the pnp_rsp_if interface.
module pnp_token (
   input  logic                   clock,
   input  logic                   reset,
   input  pnp_pkg::item_type      item,
   output logic                   advance,
   input  logic                   csr_wr_en,
   input  logic [pnp_pkg::CNT_W-1:0] csr_wr_data,
   pnp_rsp_if.source              rsp
);
   import pnp_pkg::*;

   logic [CNT_W-1:0]     bell_count_ff;
   logic [CNT_W-1:0]     cursor_ff, cursor_in;
   logic [NUM_PAIRS-1:0] pending_ff, pending_in;
   logic                 expect_first_ff, expect_first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NUM_PAIRS-1:0] mask_ff;
   logic [PERM_W-1:0]    perm_ff;

   place_type            pl;
   logic                 is_cross;
   logic                 hit;
   logic                 take;
   logic [CNT_W-1:0]     place_ext;
   logic [CNT_W-1:0]     cur_start;
   logic [CNT_W-1:0]     cur_next;
   logic [CNT_W-1:0]     n_eff;
   logic [NUM_PAIRS-1:0] mask_next;
   logic [NUM_PAIRS-1:0] mask_final;
   logic [PERM_W-1:0]    perm_final;
   logic [POS_W-1:0]     pos;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bell_count_ff <= BELL_COUNT_RESET;
      end else if (csr_wr_en) begin
         bell_count_ff <= csr_wr_data;
      end
   end

   assign n_eff = (bell_count_ff > BELL_COUNT_MAX) ? BELL_COUNT_MAX : bell_count_ff;

   // A non-final character never needs the result register.
   assign advance = item.valid && (!item.last || !rsp_valid_ff || rsp.ready);

   // Decode and the special handling of the first character of a token.
   always_comb begin
      pl        = decode_place(item.char_code);
      place_ext = {1'b0, pl.place};
      is_cross  = (item.char_code == CHAR_CROSS_UC) || (item.char_code == CHAR_CROSS_LC) ||
                  (item.char_code == CHAR_DASH);
      hit       = pl.hit;
      cur_start = cursor_ff;
      if (expect_first_ff) begin
         if (item.last && is_cross) begin
            cur_start = '0;
            hit       = 1'b0;
         end else begin
            cur_start = (!pl.hit || pl.place[0]) ? CNT_W'(1) : CNT_W'(0);
         end
      end
      // Places below the cursor are ignored.
      take      = hit && (place_ext >= cur_start);
      mask_next = pending_ff;
      cur_next  = cur_start;
      if (take) begin
         mask_next = pending_ff | pair_range(cur_start, place_ext);
         cur_next  = place_ext + 1'b1;
      end
      mask_final = (mask_next | pair_range(cur_next, n_eff)) & pairs_below(n_eff);
   end

   // Marked pairs never touch, so each position moves by at most one place.
   always_comb begin
      for (int i = 0; i < MAX_BELLS; i++) begin
         pos = POS_W'(i);
         if (i < NUM_PAIRS) begin
            if (mask_final[i]) begin
               pos = POS_W'(i + 1);
            end
         end
         if (i > 0) begin
            if (mask_final[i-1]) begin
               pos = POS_W'(i - 1);
            end
         end
         perm_final[i*POS_W +: POS_W] = pos;
      end
   end

   // Next values of the token state and the result valid flag.
   always_comb begin
      cursor_in       = cursor_ff;
      pending_in      = pending_ff;
      expect_first_in = expect_first_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         if (item.last) begin
            cursor_in       = '0;
            pending_in      = '0;
            expect_first_in = 1'b1;
            rsp_valid_in    = 1'b1;
         end else begin
            cursor_in       = cur_next;
            pending_in      = mask_next;
            expect_first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         pending_ff      <= '0;
         expect_first_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cursor_ff       <= cursor_in;
         pending_ff      <= pending_in;
         expect_first_ff <= expect_first_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a final character moves on.
   always_ff @(posedge clock) begin
      if (advance && item.last) begin
         mask_ff <= mask_final;
         perm_ff <= perm_final;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.swap_mask   = mask_ff;
   assign rsp.permutation = perm_ff;

endmodule

// ===== hdl/place_notation_to_permutation.sv =====
// Top level of the place notation decoder: input register and token logic.
// Depends on pnp_pkg, pnp_if.sv, pnp_in_stage and pnp_token.
//
//   Channel   Direction  Payload                         Transaction
//   req_ch    in         char_code[7:0], last            valid && ready
//   rsp_ch    out        swap_mask[14:0], permutation    valid && ready
//   csr_*     in         bell_count[4:0]                 csr_wr_en high
//
// One character is taken every cycle while no stalled result holds the input register;
// a result is offered once its final character moves on into the result register.
// A stalled result holds only the final character of the next token back;
// other characters keep flowing. Reset is synchronous and active high, and
// leaves the bell count at eight and the block ready for a new token.
module place_notation_to_permutation (
   input  logic                      clock,
   input  logic                      reset,
   pnp_req_if.sink                   req_ch,
   pnp_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [pnp_pkg::CNT_W-1:0] csr_wr_data
);
   import pnp_pkg::*;

   item_type item;
   logic     advance;

   // Input register.
   pnp_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .advance (advance),
      .item    (item)
   );

   // Token state and result register.
   pnp_token u_token (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .advance     (advance),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp_ch)
   );

endmodule

// ===== hdl/pnp_checker.sv =====
// Port-level checks on the place notation decoder, bound to the top level.
// Depends on pnp_pkg and place_notation_to_permutation_defines.svh.
`include "place_notation_to_permutation_defines.svh"

module pnp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pnp_pkg::NUM_PAIRS-1:0] rsp_swap_mask,
   input logic [pnp_pkg::PERM_W-1:0]    rsp_permutation
);
   import pnp_pkg::*;

   localparam logic [PERM_W-1:0] IDENTITY = 64'hFEDC_BA98_7654_3210;

   // No result is offered in the cycle after reset.
   `PNP_ASSERT_ALWAYS(a_no_rsp_after_reset, clock,
                      $past(reset) && !reset |-> !rsp_valid,
                      "result valid after reset")

   // A stalled result holds its transaction.
   `PNP_ASSERT(a_rsp_hold, clock, reset,
               rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_swap_mask)
                  && $stable(rsp_permutation),
               "stalled result changed")

   // Swapped pairs never share a position.
   `PNP_ASSERT(a_pairs_apart, clock, reset,
               rsp_valid |-> ((rsp_swap_mask & (rsp_swap_mask >> 1)) == '0),
               "adjacent swaps in mask")

   // An empty mask gives the identity change.
   `PNP_ASSERT(a_identity, clock, reset,
               rsp_valid && (rsp_swap_mask == '0) |-> (rsp_permutation == IDENTITY),
               "permutation disagrees with empty mask")

endmodule

bind place_notation_to_permutation pnp_checker u_pnp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_swap_mask   (rsp_ch.swap_mask),
   .rsp_permutation (rsp_ch.permutation)
);
